### hw/rtl/assert_macros.svh
// Assertion macros for the PI regulator block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate implication or plain property, sampled on aclk, off during reset.
`define PIRPD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Condition in one cycle implies expression in the next.
`define PIRPD_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (expr)) \
        else $error(msg);

`endif

### hw/rtl/pirpd_pkg.sv
// Shared types and constants of the PI regulator block.
`default_nettype none

package pirpd_pkg;

    localparam int SPP_DEF         = 8;
    localparam int SAMPLE_BITS_DEF = 12;

    // field widths
    localparam int SAMPLE_W    = 12;
    localparam int SETP_W      = 12;
    localparam int AVG_W       = 12;
    localparam int ERR_W       = 13;
    localparam int IWHOLE_W    = 14;
    localparam int X100_W      = 14;
    localparam int CMP_W       = 16;
    localparam int DUTY_W      = 7;
    localparam int GAIN_W      = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 80;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (AVG_W + ERR_W + IWHOLE_W + X100_W + CMP_W
                                                + DUTY_W);

    // datapath widths
    localparam int INT_W  = 17;
    localparam int P1_W   = 30;
    localparam int P2_W   = 34;
    localparam int S10_W  = 36;
    localparam int S10C_W = 26;
    localparam int Q_W    = 23;
    localparam int CHI_W  = 23;
    localparam int OUT_FRAC = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOP = 2'd2;

    localparam logic [GAIN_W-1:0] KP_RESET  = 16'd655;
    localparam logic [GAIN_W-1:0] KI_RESET  = 16'd131;
    localparam logic [CMP_W-1:0]  TOP_RESET = 16'd999;

    // integral kept in tenths
    localparam logic signed [INT_W-1:0] INT_LIMIT = 17'sd50000;

    // output sum at ten times Q7.16 percent
    localparam logic signed [S10_W-1:0] S10_MID = 36'sd32768000;
    localparam logic [S10C_W-1:0]       S10_MAX = 26'd65536000;

    // reciprocal multipliers: floor(n/d) = (n*M) >> SH over the needed range
    localparam logic [S10C_W-1:0] RECIP10_M   = 26'd53687092;
    localparam int                RECIP10_SH  = 29;
    localparam logic [16:0]       IREC_M      = 17'd104858;
    localparam int                IREC_SH     = 20;
    localparam logic [23:0]       RECIP100_M  = 24'd10737419;
    localparam int                RECIP100_SH = 30;

    localparam logic [15:0] ROUND_HALF = 16'h8000;
    localparam logic [21:0] CMP_BIAS   = 22'd3276800;
    localparam logic [6:0]  PCT_SCALE  = 7'd100;

    typedef struct packed {
        logic [GAIN_W-1:0] kp_gain;
        logic [GAIN_W-1:0] ki_gain;
        logic [CMP_W-1:0]  period_top;
    } cfg_t;

    typedef struct packed {
        logic [OUT_PAD_W-1:0]       pad;
        logic [DUTY_W-1:0]          duty_percent;
        logic [CMP_W-1:0]           compare_value;
        logic [X100_W-1:0]          out_hundredths;
        logic signed [IWHOLE_W-1:0] integral_whole;
        logic signed [ERR_W-1:0]    error_value;
        logic [AVG_W-1:0]           average;
    } result_t;

endpackage

`default_nettype wire

### hw/rtl/pirpd_front.sv
// Front end: takes sample words, sums good samples, queues one job per period that has a good sample.
`default_nettype none

module pirpd_front import pirpd_pkg::*; #(
    parameter int SAMPLES_PER_PERIOD = SPP_DEF,
    parameter int SAMPLE_BITS        = SAMPLE_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [SAMPLE_W-1:0] sample,
    input  wire logic                sample_ok,
    input  wire logic [SETP_W-1:0]   setpoint,
    output logic                     job_push,
    input  wire logic                job_full,
    output logic [SAMPLE_W+$clog2(SAMPLES_PER_PERIOD+1)-1:0] job_sum,
    output logic [$clog2(SAMPLES_PER_PERIOD+1)-1:0]          job_cnt,
    output logic [SETP_W-1:0]        job_setp
);

    localparam int SMP_W = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int CNT_W = $clog2(SAMPLES_PER_PERIOD + 1);
    localparam int SUM_W = SAMPLE_W + CNT_W;
    localparam int IDX_W = (SAMPLES_PER_PERIOD > 1) ? $clog2(SAMPLES_PER_PERIOD) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SAMPLES_PER_PERIOD - 1);

    logic [SUM_W-1:0] sum_reg, sum_next, sum_add;
    logic [CNT_W-1:0] cnt_reg, cnt_next, cnt_add;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [SMP_W-1:0] smp;
    logic             accept;
    logic             last;

    assign s_tready = !job_full;
    assign accept   = s_tvalid && s_tready;
    assign smp      = SMP_W'(sample);
    assign last     = (idx_reg == IDX_LAST);
    assign sum_add  = sum_reg + (sample_ok ? SUM_W'(smp) : '0);
    assign cnt_add  = cnt_reg + CNT_W'(sample_ok);

    assign job_push = accept && last && (cnt_add != '0);
    assign job_sum  = sum_add;
    assign job_cnt  = cnt_add;
    assign job_setp = setpoint;

    always_comb begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (accept) begin
            if (last) begin
                sum_next = '0;
                cnt_next = '0;
                idx_next = '0;
            end else begin
                sum_next = sum_add;
                cnt_next = cnt_add;
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            cnt_reg <= '0;
            idx_reg <= '0;
        end else begin
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/pirpd_queue.sv
// Two-entry job queue between front and back end.
`default_nettype none

module pirpd_queue #(
    parameter int WIDTH = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] din,
    output logic                  full,
    output logic                  valid,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      dout
);

    logic [WIDTH-1:0] slot0_reg, slot0_next;
    logic [WIDTH-1:0] slot1_reg, slot1_next;
    logic [1:0]       cnt_reg, cnt_next;

    assign full  = (cnt_reg == 2'd2);
    assign valid = (cnt_reg != 2'd0);
    assign dout  = slot0_reg;

    always_comb begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_reg;
        case ({push, pop})
            2'b11: begin
                if (cnt_reg == 2'd1) begin
                    slot0_next = din;
                end else begin
                    slot0_next = slot1_reg;
                    slot1_next = din;
                end
            end
            2'b01: begin
                slot0_next = slot1_reg;
                cnt_next   = cnt_reg - 2'd1;
            end
            2'b10: begin
                if (cnt_reg == 2'd0) begin
                    slot0_next = din;
                end else begin
                    slot1_next = din;
                end
                cnt_next = cnt_reg + 2'd1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

`default_nettype wire

### hw/rtl/pirpd_back.sv
// Back end: divide, PI update, output scaling and result register.
`default_nettype none

module pirpd_back import pirpd_pkg::*; #(
    parameter int SAMPLES_PER_PERIOD = SPP_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cfg_t              cfg,
    input  wire logic              job_valid,
    output logic                   job_pop,
    input  wire logic [SAMPLE_W+$clog2(SAMPLES_PER_PERIOD+1)-1:0] job_sum,
    input  wire logic [$clog2(SAMPLES_PER_PERIOD+1)-1:0]          job_cnt,
    input  wire logic [SETP_W-1:0] job_setp,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output result_t                result
);

    localparam int CNT_W  = $clog2(SAMPLES_PER_PERIOD + 1);
    localparam int SUM_W  = SAMPLE_W + CNT_W;
    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(SUM_W - 1);
    localparam logic signed [INT_W:0] INT_HI = (INT_W+1)'(INT_LIMIT);
    localparam logic signed [INT_W:0] INT_LO = -INT_HI;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIV   = 4'd1;
    localparam logic [3:0] S_ERR   = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_SUM   = 4'd4;
    localparam logic [3:0] S_QUO   = 4'd5;
    localparam logic [3:0] S_SCALE = 4'd6;
    localparam logic [3:0] S_CMP   = 4'd7;
    localparam logic [3:0] S_WAIT  = 4'd8;

    logic [3:0]                 state_reg, state_next;
    logic [SUM_W-1:0]           quo_reg, quo_next;
    logic [CNT_W-1:0]           rem_reg, rem_next;
    logic [CNT_W-1:0]           den_reg, den_next;
    logic [STEP_W-1:0]          step_reg, step_next;
    logic [SETP_W-1:0]          setp_reg, setp_next;
    logic signed [ERR_W-1:0]    err_reg, err_next;
    logic signed [INT_W-1:0]    integ_reg, integ_next;
    logic signed [P1_W-1:0]     p1_reg, p1_next;
    logic signed [P2_W-1:0]     p2_reg, p2_next;
    logic [S10C_W-1:0]          s10_reg, s10_next;
    logic [Q_W-1:0]             q_reg, q_next;
    logic signed [IWHOLE_W-1:0] iw_reg, iw_next;
    logic [X100_W-1:0]          x100_reg, x100_next;
    logic [DUTY_W-1:0]          duty_reg, duty_next;
    logic [CHI_W-1:0]           chi_reg, chi_next;
    logic [CMP_W-1:0]           cmp_reg, cmp_next;
    result_t                    res_reg, res_next;
    logic                       valid_reg, valid_next;

    // restoring divider step
    logic [CNT_W:0]             rem_shift, rem_diff;
    logic                       div_bit;
    logic [AVG_W-1:0]           avg_val;
    // error and integral
    logic signed [ERR_W-1:0]    err_calc;
    logic signed [INT_W:0]      int_sum;
    logic signed [INT_W-1:0]    int_clamp;
    // products and scaling
    logic signed [GAIN_W:0]     kp_s, ki_s;
    logic signed [S10_W-1:0]    p1x, p2x, s10_full;
    logic [S10C_W-1:0]          s10_clamp;
    logic [2*S10C_W-1:0]        qprod;
    logic [15:0]                iabs;
    logic [32:0]                iprod;
    logic [IWHOLE_W-1:0]        iw_mag;
    logic [29:0]                x100_sum;
    logic [Q_W:0]               duty_sum;
    logic [CMP_W:0]             top1;
    logic [40:0]                csum;
    logic [CHI_W+23:0]          cq;
    logic [CMP_W:0]             cmp_full;

    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};
    assign div_bit   = (rem_shift >= {1'b0, den_reg});
    assign avg_val   = AVG_W'(quo_reg);

    assign err_calc = $signed({1'b0, setp_reg}) - $signed({1'b0, avg_val});
    assign int_sum  = {integ_reg[INT_W-1], integ_reg}
                    + {{(INT_W+1-ERR_W){err_calc[ERR_W-1]}}, err_calc};

    always_comb begin
        if (int_sum > INT_HI) begin
            int_clamp = INT_LIMIT;
        end else if (int_sum < INT_LO) begin
            int_clamp = -INT_LIMIT;
        end else begin
            int_clamp = int_sum[INT_W-1:0];
        end
    end

    assign kp_s = {1'b0, cfg.kp_gain};
    assign ki_s = {1'b0, cfg.ki_gain};

    assign p1x      = {{(S10_W-P1_W){p1_reg[P1_W-1]}}, p1_reg};
    assign p2x      = {{(S10_W-P2_W){p2_reg[P2_W-1]}}, p2_reg};
    assign s10_full = (p1x <<< 3) + (p1x <<< 1) + p2x + S10_MID;

    always_comb begin
        if (s10_full[S10_W-1]) begin
            s10_clamp = '0;
        end else if (s10_full[S10_W-2:0] > (S10_W-1)'(S10_MAX)) begin
            s10_clamp = S10_MAX;
        end else begin
            s10_clamp = s10_full[S10C_W-1:0];
        end
    end

    // integral / 10 toward zero through its magnitude
    assign iabs   = integ_reg[INT_W-1] ? 16'(-integ_reg) : 16'(integ_reg);
    assign iprod  = iabs * IREC_M;
    assign iw_mag = {1'b0, iprod[IREC_SH +: IWHOLE_W-1]};

    assign qprod    = s10_reg * RECIP10_M;
    assign x100_sum = q_reg * PCT_SCALE + 30'(ROUND_HALF);
    assign duty_sum = {1'b0, q_reg} + (Q_W+1)'(ROUND_HALF);
    assign top1     = {1'b0, cfg.period_top} + 1'b1;
    assign csum     = top1 * q_reg + 41'(CMP_BIAS);
    assign cq       = chi_reg * RECIP100_M;
    assign cmp_full = cq[RECIP100_SH +: CMP_W+1];

    always_comb begin
        state_next = state_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        step_next  = step_reg;
        setp_next  = setp_reg;
        err_next   = err_reg;
        integ_next = integ_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        s10_next   = s10_reg;
        q_next     = q_reg;
        iw_next    = iw_reg;
        x100_next  = x100_reg;
        duty_next  = duty_reg;
        chi_next   = chi_reg;
        cmp_next   = cmp_reg;
        res_next   = res_reg;
        valid_next = valid_reg && !m_tready;
        job_pop    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (job_valid) begin
                    job_pop    = 1'b1;
                    quo_next   = job_sum;
                    den_next   = job_cnt;
                    setp_next  = job_setp;
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                quo_next  = {quo_reg[SUM_W-2:0], div_bit};
                rem_next  = div_bit ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
                step_next = step_reg + 1'b1;
                if (step_reg == DIV_LAST) begin
                    state_next = S_ERR;
                end
            end
            S_ERR: begin
                err_next   = err_calc;
                integ_next = int_clamp;
                state_next = S_MUL;
            end
            S_MUL: begin
                p1_next    = kp_s * err_reg;
                p2_next    = ki_s * integ_reg;
                state_next = S_SUM;
            end
            S_SUM: begin
                s10_next   = s10_clamp;
                iw_next    = integ_reg[INT_W-1] ? -iw_mag : iw_mag;
                state_next = S_QUO;
            end
            S_QUO: begin
                q_next     = qprod[RECIP10_SH +: Q_W];
                state_next = S_SCALE;
            end
            S_SCALE: begin
                x100_next  = x100_sum[OUT_FRAC +: X100_W];
                duty_next  = duty_sum[OUT_FRAC +: DUTY_W];
                chi_next   = csum[OUT_FRAC +: CHI_W];
                state_next = S_CMP;
            end
            S_CMP: begin
                cmp_next   = (cmp_full > {1'b0, cfg.period_top}) ? cfg.period_top
                                                                  : cmp_full[CMP_W-1:0];
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (!valid_reg || m_tready) begin
                    res_next.pad            = '0;
                    res_next.duty_percent   = duty_reg;
                    res_next.compare_value  = cmp_reg;
                    res_next.out_hundredths = x100_reg;
                    res_next.integral_whole = iw_reg;
                    res_next.error_value    = err_reg;
                    res_next.average        = avg_val;
                    valid_next              = 1'b1;
                    state_next              = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            integ_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            integ_reg <= integ_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        step_reg <= step_next;
        setp_reg <= setp_next;
        err_reg  <= err_next;
        p1_reg   <= p1_next;
        p2_reg   <= p2_next;
        s10_reg  <= s10_next;
        q_reg    <= q_next;
        iw_reg   <= iw_next;
        x100_reg <= x100_next;
        duty_reg <= duty_next;
        chi_reg  <= chi_next;
        cmp_reg  <= cmp_next;
        res_reg  <= res_next;
    end

    assign m_tvalid = valid_reg;
    assign result   = res_reg;

endmodule

`default_nettype wire

### hw/rtl/pi_regulator_pwm_duty_top.sv
// Top level of the PI regulator with PWM duty output.
// Input: one word per cycle while the two-entry job queue has room.
// Back end: bit-serial divider over SUM_W bits (SUM_W = 16 by default), then the error,
// product, sum, quotient, scaling and compare states; it pops a job only when idle.
// Reset (aresetn low, synchronous): clears counters, integral, queue and output valid;
// gains and period_top return to 655, 131 and 999.
`default_nettype none
`include "assert_macros.svh"

module pi_regulator_pwm_duty_top import pirpd_pkg::*; #(
    parameter int SAMPLES_PER_PERIOD = SPP_DEF,
    parameter int SAMPLE_BITS        = SAMPLE_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // sample[11:0], setpoint[23:12]
    input  wire logic                   s_tuser,   // sample_ok[0]
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,   // average[11:0], error_value[24:12],
                                                   // integral_whole[38:25],
                                                   // out_hundredths[52:39],
                                                   // compare_value[68:53],
                                                   // duty_percent[75:69], zero[79:76]
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [GAIN_W-1:0]      cfg_data
);

    localparam int CNT_W = $clog2(SAMPLES_PER_PERIOD + 1);
    localparam int SUM_W = SAMPLE_W + CNT_W;
    localparam int JOB_W = SETP_W + CNT_W + SUM_W;

    cfg_t             cfg_reg, cfg_next;
    logic             job_push, job_full, job_valid, job_pop;
    logic [SUM_W-1:0] push_sum, pop_sum;
    logic [CNT_W-1:0] push_cnt, pop_cnt;
    logic [SETP_W-1:0] push_setp, pop_setp;
    logic [JOB_W-1:0] job_in, job_out;
    result_t          result;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_KP:  cfg_next.kp_gain    = cfg_data;
                REG_KI:  cfg_next.ki_gain    = cfg_data;
                REG_TOP: cfg_next.period_top = cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kp_gain    <= KP_RESET;
            cfg_reg.ki_gain    <= KI_RESET;
            cfg_reg.period_top <= TOP_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    pirpd_front #(
        .SAMPLES_PER_PERIOD (SAMPLES_PER_PERIOD),
        .SAMPLE_BITS        (SAMPLE_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .sample    (s_tdata[SAMPLE_W-1:0]),
        .sample_ok (s_tuser),
        .setpoint  (s_tdata[SAMPLE_W +: SETP_W]),
        .job_push  (job_push),
        .job_full  (job_full),
        .job_sum   (push_sum),
        .job_cnt   (push_cnt),
        .job_setp  (push_setp)
    );

    assign job_in = {push_setp, push_cnt, push_sum};

    pirpd_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (job_push),
        .din     (job_in),
        .full    (job_full),
        .valid   (job_valid),
        .pop     (job_pop),
        .dout    (job_out)
    );

    assign pop_sum  = job_out[SUM_W-1:0];
    assign pop_cnt  = job_out[SUM_W +: CNT_W];
    assign pop_setp = job_out[SUM_W + CNT_W +: SETP_W];

    pirpd_back #(
        .SAMPLES_PER_PERIOD (SAMPLES_PER_PERIOD)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .job_sum   (pop_sum),
        .job_cnt   (pop_cnt),
        .job_setp  (pop_setp),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .result    (result)
    );

    assign m_tdata = result;

    `PIRPD_ASSERT(a_queue_no_overflow, job_push |-> !job_full, "job pushed into full queue")
    `PIRPD_ASSERT_NEXT(a_queue_holds_push, job_push, job_valid, "pushed job not in queue")
    `PIRPD_ASSERT(a_duty_matches_x100,
        m_tvalid |-> ((32'(result.duty_percent) * 32'd100 <= 32'(result.out_hundredths) + 32'd50)
        && (32'(result.out_hundredths) <= 32'(result.duty_percent) * 32'd100 + 32'd50)),
        "duty and hundredths output disagree")

endmodule

`default_nettype wire
